[design/sdis_pkg.sv]
// Shared types, codes and constants of the SD card initialization sequencer.
package sdis_pkg;

  // Phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CMD0   = 3'd1;
  localparam logic [2:0] PH_CMD8   = 3'd2;
  localparam logic [2:0] PH_CMD55  = 3'd3;
  localparam logic [2:0] PH_ACMD41 = 3'd4;
  localparam logic [2:0] PH_CMD2   = 3'd5;
  localparam logic [2:0] PH_CMD3   = 3'd6;

  // Event modes
  localparam logic MODE_START    = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  // Response kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_LONG  = 2'd2;

  // Delay classes
  localparam logic [1:0] WT_NONE  = 2'd0;
  localparam logic [1:0] WT_SHORT = 2'd1;
  localparam logic [1:0] WT_LONG  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOCARD  = 3'd1;
  localparam logic [2:0] ST_PATTERN = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_CID     = 3'd4;
  localparam logic [2:0] ST_ADDRESS = 3'd5;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP_CMD   = 6'd55;

  // Configuration register indexes
  localparam logic CFG_MAX_ATTEMPTS = 1'b0;
  localparam logic CFG_OP_COND_ARG  = 1'b1;

  // Constants
  localparam logic [31:0] IF_COND_ARG     = 32'h0000_01AA;
  localparam logic [31:0] IF_COND_MASK    = 32'h0000_0FFF;
  localparam int          OCR_READY_BIT   = 31;
  localparam int          OCR_CCS_BIT     = 30;
  localparam logic [12:0] MAX_ATTEMPTS_RST = 13'd5000;
  localparam logic [31:0] OP_COND_ARG_RST  = 32'h40FF_8000;

  typedef struct packed {
    logic        mode;
    logic        cmd_failed;
    logic [31:0] response_word;
  } event_t;

  typedef struct packed {
    logic        finished;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [1:0]  response_kind;
    logic [1:0]  wait_class;
    logic [2:0]  status_code;
    logic        high_capacity;
    logic [15:0] card_address;
  } result_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [12:0] attempt_count;
    logic        capacity_flag;
    logic [15:0] address_store;
  } seq_state_t;

  typedef struct packed {
    logic [12:0] max_attempts;
    logic [31:0] op_cond_argument;
  } seq_cfg_t;

endpackage

[design/sdis_step.sv]
// Next-state and result decode for one sequencer event.
module sdis_step (
  input  sdis_pkg::seq_state_t state,
  input  sdis_pkg::seq_cfg_t   cfg,
  input  sdis_pkg::event_t     ev,
  output sdis_pkg::seq_state_t state_next,
  output sdis_pkg::result_t    res,
  output logic                 has_result
);

  sdis_pkg::result_t r;

  always_comb begin
    state_next = state;
    has_result = 1'b1;
    r          = '0;

    if (ev.mode == sdis_pkg::MODE_START) begin
      // Restart the sequence from CMD0
      state_next.attempt_count = '0;
      state_next.capacity_flag = 1'b0;
      state_next.address_store = '0;
      state_next.phase         = sdis_pkg::PH_CMD0;
      r.cmd_index              = sdis_pkg::CMD_GO_IDLE;
    end else begin
      case (state.phase)
        sdis_pkg::PH_CMD0: begin
          if (ev.cmd_failed) begin
            state_next.phase = sdis_pkg::PH_IDLE;
            r.finished       = 1'b1;
            r.status_code    = sdis_pkg::ST_NOCARD;
          end else begin
            state_next.phase = sdis_pkg::PH_CMD8;
            r.cmd_index      = sdis_pkg::CMD_IF_COND;
            r.cmd_argument   = sdis_pkg::IF_COND_ARG;
            r.response_kind  = sdis_pkg::RK_SHORT;
            r.wait_class     = sdis_pkg::WT_LONG;
          end
        end
        sdis_pkg::PH_CMD8: begin
          if (ev.cmd_failed) begin
            state_next.phase = sdis_pkg::PH_IDLE;
            r.finished       = 1'b1;
            r.status_code    = sdis_pkg::ST_NOCARD;
          end else if ((ev.response_word & sdis_pkg::IF_COND_MASK)
                       != sdis_pkg::IF_COND_ARG) begin
            state_next.phase = sdis_pkg::PH_IDLE;
            r.finished       = 1'b1;
            r.status_code    = sdis_pkg::ST_PATTERN;
          end else begin
            state_next.attempt_count = 13'd1;
            state_next.phase         = sdis_pkg::PH_CMD55;
            r.cmd_index              = sdis_pkg::CMD_APP_CMD;
            r.response_kind          = sdis_pkg::RK_SHORT;
          end
        end
        sdis_pkg::PH_CMD55, sdis_pkg::PH_ACMD41: begin
          if ((state.phase == sdis_pkg::PH_CMD55) && !ev.cmd_failed) begin
            // CMD55 accepted: send ACMD41
            state_next.phase = sdis_pkg::PH_ACMD41;
            r.cmd_index      = sdis_pkg::CMD_OP_COND;
            r.cmd_argument   = cfg.op_cond_argument;
            r.response_kind  = sdis_pkg::RK_SHORT;
          end else if ((state.phase == sdis_pkg::PH_ACMD41) && !ev.cmd_failed &&
                       ev.response_word[sdis_pkg::OCR_READY_BIT]) begin
            // Power-up done: record capacity, go on to CMD2
            state_next.capacity_flag = ev.response_word[sdis_pkg::OCR_CCS_BIT];
            state_next.phase         = sdis_pkg::PH_CMD2;
            r.cmd_index              = sdis_pkg::CMD_ALL_CID;
            r.response_kind          = sdis_pkg::RK_LONG;
          end else if (state.attempt_count >= cfg.max_attempts) begin
            // Attempt budget used up
            state_next.phase = sdis_pkg::PH_IDLE;
            r.finished       = 1'b1;
            r.status_code    = sdis_pkg::ST_TIMEOUT;
          end else begin
            // Retry the pair; a busy card waits longer than a failed command
            state_next.attempt_count = state.attempt_count + 13'd1;
            state_next.phase         = sdis_pkg::PH_CMD55;
            r.cmd_index              = sdis_pkg::CMD_APP_CMD;
            r.response_kind          = sdis_pkg::RK_SHORT;
            r.wait_class             = ev.cmd_failed ? sdis_pkg::WT_SHORT
                                                     : sdis_pkg::WT_LONG;
          end
        end
        sdis_pkg::PH_CMD2: begin
          if (ev.cmd_failed) begin
            state_next.phase = sdis_pkg::PH_IDLE;
            r.finished       = 1'b1;
            r.status_code    = sdis_pkg::ST_CID;
          end else begin
            state_next.phase = sdis_pkg::PH_CMD3;
            r.cmd_index      = sdis_pkg::CMD_SEND_RCA;
            r.response_kind  = sdis_pkg::RK_SHORT;
          end
        end
        sdis_pkg::PH_CMD3: begin
          state_next.phase = sdis_pkg::PH_IDLE;
          r.finished       = 1'b1;
          if (ev.cmd_failed) begin
            r.status_code = sdis_pkg::ST_ADDRESS;
          end else begin
            state_next.address_store = ev.response_word[31:16];
            r.status_code            = sdis_pkg::ST_OK;
          end
        end
        default: begin
          // Idle or unused code: drop the event
          state_next.phase = sdis_pkg::PH_IDLE;
          has_result       = 1'b0;
        end
      endcase
    end

    r.high_capacity = state_next.capacity_flag;
    r.card_address  = state_next.address_store;
  end

  assign res = r;

endmodule

[design/sd_card_init_sequencer.sv]
// Top level of the SD card initialization sequencer.
// Each request on the event channel is a start (mode 0) or the completion of
// the last command asked for (mode 1); the block answers with the next
// command to send, or with finished and a status code. A request is taken in
// every cycle while the result channel does not stall: it is held in the
// event register, passes the phase decode and lands in the result register,
// from which the result is offered. A completion while no command is
// outstanding gives no result. Configuration writes (index 0 max_attempts,
// index 1 ACMD41 argument) are always taken and must only be issued while
// the block is idle.
module sd_card_init_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              event_valid,
  output logic              event_ready,
  input  sdis_pkg::event_t  event_data,
  output logic              result_valid,
  input  logic              result_ready,
  output sdis_pkg::result_t result_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  logic                 ev_valid;
  sdis_pkg::event_t     ev_data;
  sdis_pkg::seq_state_t state;
  sdis_pkg::seq_state_t state_next;
  sdis_pkg::seq_cfg_t   cfg;
  sdis_pkg::result_t    res;
  logic                 has_result;
  logic                 advance;

  sdis_step u_step (
    .state      (state),
    .cfg        (cfg),
    .ev         (ev_data),
    .state_next (state_next),
    .res        (res),
    .has_result (has_result)
  );

  // Move the held request on when its result has room, or it has none
  assign advance     = ev_valid && (!has_result || !result_valid || result_ready);
  assign event_ready = !ev_valid || advance;
  assign cfg_ready   = 1'b1;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (event_ready) begin
      ev_valid <= event_valid;
    end
    if (event_ready && event_valid) begin
      ev_data <= event_data;
    end
  end

  // Advance the sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts     <= sdis_pkg::MAX_ATTEMPTS_RST;
      cfg.op_cond_argument <= sdis_pkg::OP_COND_ARG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdis_pkg::CFG_MAX_ATTEMPTS: cfg.max_attempts     <= cfg_data[12:0];
        sdis_pkg::CFG_OP_COND_ARG:  cfg.op_cond_argument <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load or drop the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance && has_result) begin
      result_data <= res;
    end
  end

endmodule
